[src/text_console_character_engine_top_defines.svh]
// ---------------------------------------------------------------------------
// Text console character engine assertion macros
// Shared concurrent assertion forms for the engine's checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TCE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tce assertion failed");

// next-cycle implication, disabled while in reset
`define TCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tce assertion failed");

`endif

[src/tce_pkg.sv]
// ---------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, character codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COPY_COUNT = (ROWS - 1) * COLUMNS;

  localparam int unsigned CELL_AW = 11;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CELL_W  = 16;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_PUT,
    KIND_TAB,
    KIND_BS,
    KIND_NL,
    KIND_CR,
    KIND_FF
  } item_kind_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_BACK,
    CUR_NL,
    CUR_CR,
    CUR_HOME,
    CUR_CLAMP
  } cur_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT_CH,
    MEM_PUT_SP,
    MEM_FILL,
    MEM_INIT,
    MEM_COPY,
    MEM_READ
  } mem_op_e;

  typedef struct packed {
    logic    load_item;
    cur_op_e cur_op;
    mem_op_e mem_op;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    set_scroll;
    logic    out_load;
  } tce_cmd_t;

  typedef struct packed {
    item_kind_e kind;
    logic       row_at_end;
    logic       cnt_last;
    logic       copy_last;
  } tce_status_t;

endpackage

[src/tce_ctrl.sv]
// ---------------------------------------------------------------------------
// Text console controller
// Sequences one word at a time: decode, cell writes, tab expansion,
// screen clear, scroll copy and result hand-off.
// ---------------------------------------------------------------------------
module tce_ctrl
  import tce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  tce_status_t status_i,
  output tce_cmd_t    cmd_o
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXEC    = 4'd2;
  localparam logic [3:0] S_TAB     = 4'd3;
  localparam logic [3:0] S_BSPUT   = 4'd4;
  localparam logic [3:0] S_CLEAR   = 4'd5;
  localparam logic [3:0] S_CHECK   = 4'd6;
  localparam logic [3:0] S_COPY    = 4'd7;
  localparam logic [3:0] S_SCRTAIL = 4'd8;
  localparam logic [3:0] S_BLANK   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] tab_rem_q, tab_rem_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.cur_op     = CUR_HOLD;
    cmd_o.mem_op     = MEM_NONE;
    state_d          = state_q;
    tab_rem_d        = tab_rem_q;

    unique case (state_q)
      S_INIT: begin
        cmd_o.mem_op  = MEM_INIT;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_CHECK;
        case (status_i.kind)
          KIND_READ: cmd_o.mem_op = MEM_READ;
          KIND_PUT: begin
            cmd_o.mem_op = MEM_PUT_CH;
            cmd_o.cur_op = CUR_ADV;
          end
          KIND_TAB: begin
            // first of four spaces here, three more through S_TAB
            cmd_o.mem_op = MEM_PUT_SP;
            cmd_o.cur_op = CUR_ADV;
            tab_rem_d    = 2'd3;
          end
          KIND_BS: begin
            cmd_o.cur_op = CUR_BACK;
            state_d      = S_BSPUT;
          end
          KIND_NL: cmd_o.cur_op = CUR_NL;
          KIND_CR: cmd_o.cur_op = CUR_CR;
          KIND_FF: begin
            cmd_o.cur_op = CUR_HOME;
            state_d      = S_CLEAR;
          end
          default: state_d = S_CHECK;
        endcase
      end
      S_TAB: begin
        cmd_o.mem_op = MEM_PUT_SP;
        cmd_o.cur_op = CUR_ADV;
        state_d      = S_CHECK;
      end
      S_BSPUT: begin
        cmd_o.mem_op = MEM_PUT_SP;
        state_d      = S_CHECK;
      end
      S_CLEAR: begin
        cmd_o.mem_op  = MEM_FILL;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.row_at_end) begin
          cmd_o.set_scroll = 1'b1;
          state_d          = S_COPY;
        end else if (tab_rem_q != 2'd0) begin
          tab_rem_d = tab_rem_q - 2'd1;
          state_d   = S_TAB;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_COPY: begin
        cmd_o.mem_op  = MEM_COPY;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.copy_last) begin
          state_d = S_SCRTAIL;
        end
      end
      S_SCRTAIL: begin
        // last copied cell lands here, the counter already points at the bottom row
        state_d = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.mem_op  = MEM_FILL;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.cur_op  = CUR_CLAMP;
          state_d       = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      tab_rem_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_rem_q   <= tab_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/tce_datapath.sv]
// ---------------------------------------------------------------------------
// Text console datapath
// Cell store, cursor, attribute register, sweep counter and result register.
// ---------------------------------------------------------------------------
module tce_datapath
  import tce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tce_cmd_t            cmd_i,
  output tce_status_t         status_o,
  input  logic                action_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [CELL_AW-1:0]  cell_index_i,
  input  logic                cfg_valid_i,
  input  logic [CHAR_W-1:0]   cfg_data_i,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic [ROW_W-1:0]    cursor_row_out_o,
  output logic [COL_W-1:0]    cursor_col_out_o,
  output logic                scrolled_o
);

  logic [CELL_W-1:0]  mem [CELL_COUNT];

  logic               action_q;
  logic [CHAR_W-1:0]  char_q;
  logic [CELL_AW-1:0] idx_q;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [CHAR_W-1:0]  attr_q;
  logic [CELL_AW-1:0] cnt_q;
  logic               scroll_q;
  logic               pend_q;
  logic [CELL_AW-1:0] pend_addr_q;
  logic [CELL_W-1:0]  rdata_q;
  logic [CELL_W-1:0]  out_cell_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic               out_scroll_q;

  logic [CELL_AW-1:0] cur_addr;
  logic               idx_ok;
  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata;
  item_kind_e         kind;

  assign cur_addr = CELL_AW'(row_q) * CELL_AW'(COLUMNS) + CELL_AW'(col_q);
  assign idx_ok   = idx_q < CELL_AW'(CELL_COUNT);

  always_comb begin
    if (action_q) begin
      kind = KIND_READ;
    end else begin
      unique case (char_q) inside
        CH_BS:        kind = KIND_BS;
        CH_TAB:       kind = KIND_TAB;
        CH_LF, CH_VT: kind = KIND_NL;
        CH_FF:        kind = KIND_FF;
        CH_CR:        kind = KIND_CR;
        default:      kind = KIND_PUT;
      endcase
    end
  end

  assign status_o.kind       = kind;
  assign status_o.row_at_end = (row_q == ROW_W'(ROWS));
  assign status_o.cnt_last   = (cnt_q == CELL_AW'(CELL_COUNT - 1));
  assign status_o.copy_last  = (cnt_q == CELL_AW'(COPY_COUNT - 1));

  // cursor update
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (cmd_i.cur_op)
      CUR_ADV: begin
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      CUR_BACK: begin
        if (col_q != '0) begin
          col_d = col_q - COL_W'(1);
        end else if (row_q != '0) begin
          row_d = row_q - ROW_W'(1);
          col_d = COL_W'(COLUMNS - 1);
        end
      end
      CUR_NL: begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end
      CUR_CR:    col_d = '0;
      CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      CUR_CLAMP: row_d = ROW_W'(ROWS - 1);
      default: begin
        row_d = row_q;
        col_d = col_q;
      end
    endcase
  end

  // memory port selection, a pending copy write owns the write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = {attr_q, CH_SPACE};
    mem_re    = 1'b0;
    mem_raddr = cnt_q + CELL_AW'(COLUMNS);
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = rdata_q;
    end else begin
      case (cmd_i.mem_op)
        MEM_PUT_CH: begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {attr_q, char_q};
        end
        MEM_PUT_SP: begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
        end
        MEM_FILL: mem_we = 1'b1;
        MEM_INIT: begin
          mem_we    = 1'b1;
          mem_wdata = CELL_RESET;
        end
        default: mem_we = 1'b0;
      endcase
    end
    case (cmd_i.mem_op)
      MEM_COPY: mem_re = 1'b1;
      MEM_READ: begin
        mem_re    = idx_ok;
        mem_raddr = idx_q;
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      attr_q   <= ATTR_RESET;
      cnt_q    <= '0;
      scroll_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      pend_q <= (cmd_i.mem_op == MEM_COPY);
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CELL_AW'(1);
      end
      if (cmd_i.load_item) begin
        scroll_q <= 1'b0;
      end else if (cmd_i.set_scroll) begin
        scroll_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q;
    if (cmd_i.load_item) begin
      action_q <= action_i;
      char_q   <= char_code_i;
      idx_q    <= cell_index_i;
    end
    if (cmd_i.out_load) begin
      out_cell_q   <= (action_q && idx_ok) ? rdata_q : '0;
      out_row_q    <= row_q;
      out_col_q    <= col_q;
      out_scroll_q <= scroll_q;
    end
  end

  assign cell_value_o     = out_cell_q;
  assign cursor_row_out_o = out_row_q;
  assign cursor_col_out_o = out_col_q;
  assign scrolled_o       = out_scroll_q;

endmodule

[src/text_console_character_engine_top.sv]
// ---------------------------------------------------------------------------
// Text console character engine
// Terminal-style character handler over an 80x25 text cell store.
// ---------------------------------------------------------------------------
// One word is handled at a time against a cell memory with one write port and
// one read port. After reset the block sweeps all 2000 cells to blank white and
// holds in_stall_o high until the sweep ends; attribute writes are taken during
// that time. A word is taken only after the result of the word before it has
// been loaded into the result register. Backspace moves the cursor back before
// writing its space, tab writes four spaces, and form feed clears the screen
// with a one-cell-per-cycle sweep. Every scroll copies the rows up one cell per
// cycle through the memory read port, then blanks the bottom row. A result
// waiting in the output register does not keep the next word from being
// accepted; that word's result then waits inside the block until the register
// is taken.
module text_console_character_engine_top
  import tce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [CELL_AW-1:0] cell_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CELL_W-1:0]  cell_value_o,
  output logic [ROW_W-1:0]   cursor_row_out_o,
  output logic [COL_W-1:0]   cursor_col_out_o,
  output logic               scrolled_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CHAR_W-1:0]  cfg_data_i
);

  tce_cmd_t    cmd;
  tce_status_t status;

  // attribute register sits apart from the sequencing, always writable
  assign cfg_ready_o = 1'b1;

  tce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tce_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .cell_value_o     (cell_value_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .scrolled_o       (scrolled_o)
  );

endmodule

[src/tce_checker.sv]
// ---------------------------------------------------------------------------
// Text console checker
// Port-level checks on the engine, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "text_console_character_engine_top_defines.svh"

module tce_checker
  import tce_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CELL_W-1:0]  cell_value_o,
  input logic [ROW_W-1:0]   cursor_row_out_o,
  input logic [COL_W-1:0]   cursor_col_out_o,
  input logic               scrolled_o
);

  // reported cursor always lies on the screen
  `TCE_ASSERT_IMP(a_cursor_range, clk_i, rst_ni, out_valid_o, (cursor_row_out_o < ROW_W'(ROWS)) && (cursor_col_out_o < COL_W'(COLUMNS)))

  // a scroll always leaves the cursor on the bottom row
  `TCE_ASSERT_IMP(a_scroll_row, clk_i, rst_ni, out_valid_o && scrolled_o, cursor_row_out_o == ROW_W'(ROWS - 1))

  // one word in flight at a time
  `TCE_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `TCE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(cell_value_o) && $stable(cursor_row_out_o) && $stable(cursor_col_out_o) && $stable(scrolled_o))

endmodule

bind text_console_character_engine_top tce_checker u_tce_checker (.*);

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// Text console character engine testbench
// Feeds character and cell-read words through the stall handshake, predicts
// each result from a cycle-free model of the screen and cursor, and compares
// every result word field by field. A short directed table runs first, then
// random traffic in three idle modes with attribute changes between phases.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tce_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned ITEMS_PER_PHASE = 600;
  localparam int unsigned TAB_SPACES      = 4;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned TAIL_CYCLES     = 2100;
  localparam longint      WATCHDOG_CYCLES = 30_000_000;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_result_t;

  typedef struct packed {
    logic               act;
    logic [CHAR_W-1:0]  ch;
    logic [CELL_AW-1:0] idx;
    logic               has_want;
    console_result_t    want;
  } plan_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               action_i     = ACT_CHAR;
  logic [CHAR_W-1:0]  char_code_i  = '0;
  logic [CELL_AW-1:0] cell_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [CELL_W-1:0]  cell_value_o;
  logic [ROW_W-1:0]   cursor_row_out_o;
  logic [COL_W-1:0]   cursor_col_out_o;
  logic               scrolled_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CHAR_W-1:0]  cfg_data_i   = '0;

  // screen and cursor as the block should hold them
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int unsigned       row_model;
  int unsigned       col_model;
  logic [CHAR_W-1:0] attr_model;
  logic              scroll_seen;

  console_result_t pending_results [$];
  plan_row_t       plan_q [$];
  int              mismatch_count = 0;
  int              words_checked  = 0;
  int              hold_left      = 0;
  int              send_idle_pct  = 9;
  int              recv_idle_pct  = 75;

  text_console_character_engine_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_value_o     (cell_value_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .scrolled_o       (scrolled_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void put_cell(input logic [CHAR_W-1:0] ch, input int unsigned col,
                                   input int unsigned row);
    int unsigned pos;
    pos = row * COLUMNS + col;
    if (pos < CELL_COUNT) screen_model[pos] = {attr_model, ch};
  endfunction

  function automatic void scroll_up();
    int unsigned i;
    if (row_model >= ROWS) begin
      for (i = 0; i < COPY_COUNT; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (i = 0; i < COLUMNS; i++) put_cell(CH_SPACE, i, ROWS - 1);
      row_model   = ROWS - 1;
      scroll_seen = 1'b1;
    end
  endfunction

  function automatic void print_char(input logic [CHAR_W-1:0] ch);
    put_cell(ch, col_model, row_model);
    col_model++;
    if (col_model >= COLUMNS) begin
      col_model = 0;
      row_model++;
    end
    scroll_up();
  endfunction

  function automatic console_result_t predict_console(input logic act,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [CELL_AW-1:0] idx);
    console_result_t r;
    int unsigned k;
    r = '0;
    scroll_seen = 1'b0;
    if (act == ACT_READ) begin
      if (idx < CELL_COUNT) r.cell_val = screen_model[idx];
    end else begin
      case (ch)
        CH_BS: begin
          if (col_model > 0) begin
            col_model--;
          end else if (row_model > 0) begin
            row_model--;
            col_model = COLUMNS - 1;
          end
          put_cell(CH_SPACE, col_model, row_model);
        end
        CH_TAB: begin
          for (k = 0; k < TAB_SPACES; k++) print_char(CH_SPACE);
        end
        CH_LF, CH_VT: begin
          col_model = 0;
          row_model++;
        end
        CH_FF: begin
          for (k = 0; k < CELL_COUNT; k++) screen_model[k] = {attr_model, CH_SPACE};
          row_model = 0;
          col_model = 0;
        end
        CH_CR: col_model = 0;
        default: print_char(ch);
      endcase
      scroll_up();
    end
    r.row      = row_model[ROW_W-1:0];
    r.col      = col_model[COL_W-1:0];
    r.scrolled = scroll_seen;
    return r;
  endfunction

  function automatic plan_row_t plan_entry(input logic act, input logic [CHAR_W-1:0] ch,
                                           input logic [CELL_AW-1:0] idx,
                                           input logic has_want,
                                           input logic [CELL_W-1:0] cell_val,
                                           input int unsigned row, input int unsigned col);
    plan_row_t p;
    p               = '0;
    p.act           = act;
    p.ch            = ch;
    p.idx           = idx;
    p.has_want      = has_want;
    p.want.cell_val = cell_val;
    p.want.row      = row[ROW_W-1:0];
    p.want.col      = col[COL_W-1:0];
    p.want.scrolled = 1'b0;
    return p;
  endfunction

  // offer one word, hold it until taken, then record what should come back
  task automatic send_word(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_AW-1:0] idx, input logic has_want,
                           input console_result_t want);
    console_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_console(act, ch, idx);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  task automatic write_attribute(input logic [CHAR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    attr_model = value;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned        n;
    int unsigned        pick;
    logic               act;
    logic [CHAR_W-1:0]  ch;
    logic [CELL_AW-1:0] idx;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(999);
      act  = ACT_CHAR;
      ch   = CHAR_W'($urandom_range(255));
      // mostly inside the store, now and then past its end
      idx  = ($urandom_range(9) == 0) ? CELL_AW'($urandom_range(2047))
                                      : CELL_AW'($urandom_range(CELL_COUNT - 1));
      if (pick < 280)      act = ACT_READ;
      else if (pick < 330) ch  = CH_BS;
      else if (pick < 370) ch  = CH_TAB;
      else if (pick < 470) ch  = CH_LF;
      else if (pick < 520) ch  = CH_VT;
      else if (pick < 550) ch  = CH_CR;
      else if (pick < 552) ch  = CH_FF;
      send_word(act, ch, idx, 1'b0, '0);
    end
  endtask

  // result side: check each taken word, then pick the next stall
  always @(posedge clk_i) begin
    console_result_t oldest;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word cell %h row %0d col %0d",
                                  cell_value_o, cursor_row_out_o, cursor_col_out_o));
      end else begin
        oldest = pending_results.pop_front();
        if (cell_value_o !== oldest.cell_val)
          report_mismatch($sformatf("cell_value got %h want %h", cell_value_o,
                                    oldest.cell_val));
        if (cursor_row_out_o !== oldest.row)
          report_mismatch($sformatf("cursor_row got %0d want %0d", cursor_row_out_o,
                                    oldest.row));
        if (cursor_col_out_o !== oldest.col)
          report_mismatch($sformatf("cursor_col got %0d want %0d", cursor_col_out_o,
                                    oldest.col));
        if (scrolled_o !== oldest.scrolled)
          report_mismatch($sformatf("scrolled got %0b want %0b", scrolled_o,
                                    oldest.scrolled));
      end
      words_checked++;
      // long hold-off so the block backs up into its input
      if (words_checked == 300 || words_checked == 1300) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned waited;
    logic [CHAR_W-1:0] phase_attr [3];

    foreach (screen_model[i]) screen_model[i] = CELL_RESET;
    row_model  = 0;
    col_model  = 0;
    attr_model = ATTR_RESET;

    plan_q.push_back(plan_entry(ACT_READ, 8'h00, 11'd0,    1'b1, 16'h0F20, 0, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00, 11'd1999, 1'b1, 16'h0F20, 0, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00, 11'd2047, 1'b1, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00, 11'd2000, 1'b1, 16'h0000, 0, 0));
    // backspace at home stays put
    plan_q.push_back(plan_entry(ACT_CHAR, CH_BS,  11'd0,   1'b1, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'h41,  11'd0,   1'b1, 16'h0000, 0, 1));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd0,   1'b1, 16'h0F41, 0, 1));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'h00,  11'd0,   1'b1, 16'h0000, 0, 2));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'hFF,  11'd0,   1'b1, 16'h0000, 0, 3));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_TAB, 11'd0,   1'b1, 16'h0000, 0, 7));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_BS,  11'd0,   1'b1, 16'h0000, 0, 6));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd2,   1'b1, 16'h0FFF, 0, 6));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd1,   1'b1, 16'h0F00, 0, 6));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_CR,  11'd0,   1'b1, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_LF,  11'd0,   1'b1, 16'h0000, 1, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_VT,  11'd0,   1'b1, 16'h0000, 2, 0));
    // backspace at column 0 goes to the end of the row above
    plan_q.push_back(plan_entry(ACT_CHAR, CH_BS,  11'd0,   1'b1, 16'h0000, 1, 79));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'h7A,  11'd0,   1'b1, 16'h0000, 2, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd159, 1'b1, 16'h0F7A, 2, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'h80,  11'd0,   1'b0, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, 8'h7F,  11'd0,   1'b0, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd160, 1'b0, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_CHAR, CH_FF,  11'd0,   1'b1, 16'h0000, 0, 0));
    plan_q.push_back(plan_entry(ACT_READ, 8'h00,  11'd159, 1'b1, 16'h0F20, 0, 0));

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = CHAR_W'($urandom_range(254, 1));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[n])
      send_word(plan_q[n].act, plan_q[n].ch, plan_q[n].idx, plan_q[n].has_want,
                plan_q[n].want);
    in_valid_i <= 1'b0;

    for (ph = 0; ph < 3; ph++) begin
      // attribute only changes once the block has drained
      while (pending_results.size() != 0) @(posedge clk_i);
      write_attribute(phase_attr[ph]);
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 9 : 0;
      run_random(ITEMS_PER_PHASE);
      in_valid_i <= 1'b0;
    end

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
